// ----- rtl/multichannel_output_run_controller_defines.svh -----
// assertion macros for the run controller
// checks are clocked on clk_i; the plain form is off while rst_ni is low
`ifndef MULTICHANNEL_OUTPUT_RUN_CONTROLLER_DEFINES_SVH
`define MULTICHANNEL_OUTPUT_RUN_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MOCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MOCR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MOCR_ASSERT(lbl, prop, msg)
`define MOCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/mocr_pkg.sv -----
package mocr_pkg;

  localparam int NCH_IO       = 5;
  localparam int NCH_MAX      = 8;
  localparam int SAMPLE_W     = 12;
  localparam int LIMIT_W      = 13;
  localparam int TIME_W       = 16;
  localparam int SCALE_W      = 15;
  localparam int FRAC_BITS    = 14;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam int CHANNELS_DEF = 5;
  localparam int ADC_BITS_DEF = 12;

  // input beat: run, stop, tick, then the samples
  localparam int KEY_BITS     = 3;
  localparam int IN_FIELDS_W  = KEY_BITS + NCH_IO * SAMPLE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_DURATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FIRST  = 3'd1;

  localparam logic [TIME_W-1:0]  RUN_DURATION_RST = 16'd60;
  localparam logic [LIMIT_W-1:0] LIMIT_RST        = 13'd3000;

  // q1.14 current sense gains
  localparam logic [SCALE_W-1:0] SCALE_Q14 [NCH_MAX] = '{
    15'd16384, 15'd24691, 15'd25064, 15'd24976,
    15'd25315, 15'd16384, 15'd16384, 15'd16384
  };

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_OC   = 2'd2,
    MODE_STOP = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FLAG_WAITING = 2'd0,
    FLAG_RUNNING = 2'd1,
    FLAG_CAUTION = 2'd2
  } flag_e;

  typedef enum logic [1:0] {
    BEEP_NONE   = 2'd0,
    BEEP_SHORT  = 2'd1,
    BEEP_DOUBLE = 2'd2,
    BEEP_ALARM  = 2'd3
  } beep_e;

  typedef struct packed {
    logic tick;
    logic stop;
    logic run;
  } keys_t;

  // lowest member last so the packed value matches the output beat layout
  typedef struct packed {
    logic [TIME_W-1:0]       time_left;
    beep_e                   beep;
    flag_e [NCH_IO-1:0]      status;
    logic                    drive_enable;
    mode_e                   mode;
  } result_t;

  localparam int OUT_TDATA_W = (($bits(result_t) + 7) / 8) * 8;

endpackage

// ----- rtl/mocr_lane.sv -----
module mocr_lane import mocr_pkg::*; #(
  parameter int LANE_IDX = 0,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic [SAMPLE_W-1:0] code_i,
  input  logic [LIMIT_W-1:0]  limit_i,
  output logic                over_o
);

  localparam int MaskBits = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] CodeMask = SAMPLE_W'((64'd1 << MaskBits) - 64'd1);
  localparam int ProdW = SAMPLE_W + SCALE_W;
  localparam int MaW   = ProdW - FRAC_BITS;
  localparam int CmpW  = (MaW > LIMIT_W) ? MaW : LIMIT_W;

  logic [ProdW-1:0] prod;
  logic [MaW-1:0]   milliamps;

  // truncating q1.14 scale to milliamps
  assign prod      = ProdW'(code_i & CodeMask) * ProdW'(SCALE_Q14[LANE_IDX]);
  assign milliamps = prod[ProdW-1:FRAC_BITS];
  assign over_o    = CmpW'(milliamps) > CmpW'(limit_i);

endmodule

// ----- rtl/mocr_ctrl.sv -----
`include "multichannel_output_run_controller_defines.svh"

module mocr_ctrl import mocr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  keys_t             keys_i,
  input  logic [NCH_IO-1:0] over_i,
  input  logic [TIME_W-1:0] run_duration_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           result_o
);

  mode_e              mode_q, mode_d;
  flag_e [NCH_IO-1:0] flags_q, flags_d;
  logic [TIME_W-1:0]  countdown_q, countdown_d;
  logic               counting_q, counting_d;
  logic               outputs_on_q, outputs_on_d;
  logic               run_prev_q, run_prev_d;
  logic               out_valid_q, out_valid_d;
  result_t            result_q;
  beep_e              beep;
  logic               run_edge;
  logic               any_over;
  logic               in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign run_edge   = keys_i.run && !run_prev_q;
  assign any_over   = |over_i;

  always_comb begin
    mode_d       = mode_q;
    flags_d      = flags_q;
    countdown_d  = countdown_q;
    counting_d   = counting_q;
    outputs_on_d = outputs_on_q;
    run_prev_d   = run_prev_q;
    beep         = BEEP_NONE;
    if (in_fire) begin
      if (counting_q && keys_i.tick && (countdown_q != '0)) begin
        countdown_d = countdown_q - TIME_W'(1);
      end
      unique case (mode_q) inside
        MODE_WAIT: begin
          countdown_d = run_duration_i;
          if (!keys_i.stop) begin
            if (run_edge) begin
              beep         = BEEP_SHORT;
              counting_d   = 1'b1;
              outputs_on_d = 1'b1;
              for (int i = 0; i < NCH_IO; i++) flags_d[i] = FLAG_RUNNING;
              mode_d       = MODE_RUN;
            end
          end else if (keys_i.run) begin
            beep = BEEP_ALARM;
          end
        end
        MODE_RUN: begin
          // later rules override earlier ones
          if (run_edge) begin
            beep         = BEEP_SHORT;
            outputs_on_d = 1'b0;
            counting_d   = 1'b0;
            for (int i = 0; i < NCH_IO; i++) flags_d[i] = FLAG_WAITING;
            mode_d       = MODE_STOP;
          end
          if (countdown_d == '0) begin
            beep         = BEEP_SHORT;
            outputs_on_d = 1'b0;
            counting_d   = 1'b0;
            for (int i = 0; i < NCH_IO; i++) flags_d[i] = FLAG_WAITING;
            countdown_d  = run_duration_i;
            mode_d       = MODE_WAIT;
          end
          if (any_over) begin
            beep         = BEEP_ALARM;
            outputs_on_d = 1'b0;
            counting_d   = 1'b0;
            for (int i = 0; i < NCH_IO; i++) begin
              flags_d[i] = over_i[i] ? FLAG_CAUTION : FLAG_WAITING;
            end
            mode_d       = MODE_OC;
          end
          if (keys_i.stop) begin
            beep         = BEEP_SHORT;
            outputs_on_d = 1'b0;
            counting_d   = 1'b0;
            for (int i = 0; i < NCH_IO; i++) flags_d[i] = FLAG_WAITING;
            mode_d       = MODE_STOP;
          end
        end
        MODE_OC, MODE_STOP: begin
          if (run_edge) begin
            beep         = BEEP_DOUBLE;
            outputs_on_d = 1'b0;
            counting_d   = 1'b0;
            for (int i = 0; i < NCH_IO; i++) flags_d[i] = FLAG_WAITING;
            countdown_d  = run_duration_i;
            mode_d       = MODE_WAIT;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
      run_prev_d = keys_i.run;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_WAIT;
      for (int i = 0; i < NCH_IO; i++) flags_q[i] <= FLAG_WAITING;
      countdown_q  <= RUN_DURATION_RST;
      counting_q   <= 1'b0;
      outputs_on_q <= 1'b0;
      run_prev_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      flags_q      <= flags_d;
      countdown_q  <= countdown_d;
      counting_q   <= counting_d;
      outputs_on_q <= outputs_on_d;
      run_prev_q   <= run_prev_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      result_q.mode         <= mode_d;
      result_q.drive_enable <= outputs_on_d;
      result_q.status       <= flags_d;
      result_q.beep         <= beep;
      result_q.time_left    <= countdown_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `MOCR_ASSERT_ALWAYS(a_drive_tracks_run, (outputs_on_q == counting_q) && (outputs_on_q == (mode_q == MODE_RUN)), "drive and countdown out of step with run mode")
  `MOCR_ASSERT(a_state_holds, !in_fire |=> $stable(mode_q) && $stable(countdown_q), "state moved without a beat")
  `MOCR_ASSERT(a_alarm_mode, out_valid_q && (result_q.beep == BEEP_ALARM) |-> (result_q.mode == MODE_OC) || (result_q.mode == MODE_WAIT), "alarm beep in wrong mode")
  `MOCR_ASSERT(a_stop_wins, in_fire && keys_i.stop && (mode_q == MODE_RUN) |=> mode_q == MODE_STOP, "stop key did not end the run")

endmodule

// ----- rtl/multichannel_output_run_controller.sv -----
// timing: a result beat is valid in the cycle after its input beat is taken
// throughput: one beat per cycle while m_axis_tready does not hold back a pending result; the lane
//   scale-and-compare and the mode update both settle combinationally before the state register
// reset: asynchronous, active low; mode wait, outputs off, countdown 60,
//   run_duration 60 and all limits 3000 mA, no result pending
module multichannel_output_run_controller import mocr_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // run_button, stop_button, tick, sample_ch1 .. sample_ch5
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mode, drive_enable, status_ch1 .. status_ch5, beep_request, time_left
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int Lanes = (CHANNELS < NCH_IO) ? CHANNELS : NCH_IO;

  logic [TIME_W-1:0]  run_duration_q;
  logic [LIMIT_W-1:0] limit_q [NCH_IO];
  logic [NCH_IO-1:0]  over;
  keys_t              keys;
  result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_duration_q <= RUN_DURATION_RST;
      for (int i = 0; i < NCH_IO; i++) limit_q[i] <= LIMIT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_RUN_DURATION) begin
        run_duration_q <= cfg_data_i[TIME_W-1:0];
      end
      for (int i = 0; i < NCH_IO; i++) begin
        if (cfg_idx_i == REG_LIMIT_FIRST + CFG_IDX_W'(i)) begin
          limit_q[i] <= cfg_data_i[LIMIT_W-1:0];
        end
      end
    end
  end

  assign keys.run  = s_axis_tdata[0];
  assign keys.stop = s_axis_tdata[1];
  assign keys.tick = s_axis_tdata[2];

  for (genvar i = 0; i < NCH_IO; i++) begin : g_lane
    if (i < Lanes) begin : g_on
      mocr_lane #(
        .LANE_IDX (i),
        .ADC_BITS (ADC_BITS)
      ) u_lane (
        .code_i  (s_axis_tdata[KEY_BITS + i*SAMPLE_W +: SAMPLE_W]),
        .limit_i (limit_q[i]),
        .over_o  (over[i])
      );
    end else begin : g_off
      assign over[i] = 1'b0;
    end
  end

  mocr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .keys_i         (keys),
    .over_i         (over),
    .run_duration_i (run_duration_q),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tdata = OUT_TDATA_W'(result);

endmodule

// ----- dv/multichannel_output_run_controller_tb.sv -----
`timescale 1ns / 1ps

module multichannel_output_run_controller_tb;
  import mocr_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // run_button, stop_button, tick, sample_ch1 .. sample_ch5
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // mode, drive_enable, status_ch1 .. status_ch5, beep_request, time_left
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  multichannel_output_run_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // q1.14 current sense gains per channel
  function automatic int unsigned sense_gain(int ch);
    case (ch)
      0: return 16384;
      1: return 24691;
      2: return 25064;
      3: return 24976;
      default: return 25315;
    endcase
  endfunction

  class run_tracker;
    mode_e                mode;
    flag_e                flags [NCH_IO];
    logic [TIME_W-1:0]    countdown;
    bit                   counting;
    bit                   outputs_on;
    bit                   run_prev;
    logic [TIME_W-1:0]    duration;
    logic [LIMIT_W-1:0]   limit [NCH_IO];
    result_t              due_status [$];
    int unsigned          errors, accepted, checked, starts, expiries, trips, stops;

    function new();
      mode       = MODE_WAIT;
      countdown  = RUN_DURATION_RST;
      duration   = RUN_DURATION_RST;
      counting   = 0;
      outputs_on = 0;
      run_prev   = 0;
      foreach (flags[i]) begin
        flags[i] = FLAG_WAITING;
        limit[i] = LIMIT_RST;
      end
    endfunction

    function void halt_outputs();
      outputs_on = 0;
      counting   = 0;
      foreach (flags[i]) flags[i] = FLAG_WAITING;
    endfunction

    function void take_input(logic [IN_TDATA_W-1:0] d);
      bit                run, stop, tick, run_rise;
      bit [NCH_IO-1:0]   over;
      int unsigned       ma;
      beep_e             beep;
      result_t           r;
      run      = d[0];
      stop     = d[1];
      tick     = d[2];
      run_rise = run && !run_prev;
      for (int i = 0; i < NCH_IO; i++) begin
        ma = (32'(d[KEY_BITS + SAMPLE_W*i +: SAMPLE_W]) * sense_gain(i)) >> FRAC_BITS;
        over[i] = ma > limit[i];
      end
      beep = BEEP_NONE;
      if (counting && tick && countdown != 0) countdown--;
      case (mode)
        MODE_WAIT: begin
          countdown = duration;
          if (!stop) begin
            if (run_rise) begin
              beep       = BEEP_SHORT;
              counting   = 1;
              outputs_on = 1;
              foreach (flags[i]) flags[i] = FLAG_RUNNING;
              mode       = MODE_RUN;
              starts++;
            end
          end else if (run) begin
            beep = BEEP_ALARM;
          end
        end
        MODE_RUN: begin
          // each rule overrides the ones before it
          if (run_rise) begin
            beep = BEEP_SHORT;
            halt_outputs();
            mode = MODE_STOP;
          end
          if (countdown == 0) begin
            beep = BEEP_SHORT;
            halt_outputs();
            countdown = duration;
            mode = MODE_WAIT;
            expiries++;
          end
          if (|over) begin
            beep = BEEP_ALARM;
            halt_outputs();
            foreach (flags[i]) if (over[i]) flags[i] = FLAG_CAUTION;
            mode = MODE_OC;
            trips++;
          end
          if (stop) begin
            beep = BEEP_SHORT;
            halt_outputs();
            mode = MODE_STOP;
            stops++;
          end
        end
        default: begin
          if (run_rise) begin
            beep = BEEP_DOUBLE;
            halt_outputs();
            countdown = duration;
            mode = MODE_WAIT;
          end
        end
      endcase
      run_prev = run;
      r.mode         = mode;
      r.drive_enable = outputs_on;
      for (int i = 0; i < NCH_IO; i++) r.status[i] = flags[i];
      r.beep         = beep;
      r.time_left    = countdown;
      due_status.push_back(r);
      accepted++;
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      errors++;
    endfunction

    function void check_output(logic [OUT_TDATA_W-1:0] d);
      result_t got, want;
      got = d[$bits(result_t)-1:0];
      if (due_status.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none actual %h", $time, d);
        errors++;
        return;
      end
      want = due_status.pop_front();
      checked++;
      if (got.mode !== want.mode) report("mode", want.mode, got.mode);
      if (got.drive_enable !== want.drive_enable)
        report("drive_enable", want.drive_enable, got.drive_enable);
      for (int i = 0; i < NCH_IO; i++)
        if (got.status[i] !== want.status[i])
          report($sformatf("status_ch%0d", i + 1), want.status[i], got.status[i]);
      if (got.beep !== want.beep) report("beep_request", want.beep, got.beep);
      if (got.time_left !== want.time_left) report("time_left", want.time_left, got.time_left);
    endfunction
  endclass

  run_tracker  ctl = new();
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_off_req;
  bit          run_level;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) ctl.check_output(m_axis_tdata);
      if (hold_off_req) begin
        hold_off_req = 0;
        hold_cnt = 80;
      end
      if (hold_cnt != 0) begin
        m_axis_tready <= 1'b0;
        hold_cnt--;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [IN_TDATA_W-1:0] d);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ctl.take_input(d);
  endtask

  task automatic put(input bit r, input bit s, input bit t, input int unsigned c [NCH_IO]);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[0] = r;
    d[1] = s;
    d[2] = t;
    for (int i = 0; i < NCH_IO; i++) d[KEY_BITS + SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(c[i]);
    send_beat(d);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (ctl.due_status.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [TIME_W-1:0] dur, input logic [LIMIT_W-1:0] lim [NCH_IO]);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_RUN_DURATION;
    cfg_data_i <= dur;
    @(posedge clk_i);
    for (int i = 0; i < NCH_IO; i++) begin
      cfg_idx_i  <= REG_LIMIT_FIRST + CFG_IDX_W'(i);
      cfg_data_i <= CFG_DATA_W'(lim[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    ctl.duration = dur;
    ctl.limit    = lim;
  endtask

  // mostly key sequences with currents under the limits; a few trips and noise
  function automatic logic [IN_TDATA_W-1:0] make_random_beat();
    logic [IN_TDATA_W-1:0] d;
    int unsigned           safe, code, pick;
    d = '0;
    if ($urandom_range(0, 99) < 5) begin
      d = {$urandom, $urandom};
      d[IN_TDATA_W-1:IN_FIELDS_W] = '0;
      return d;
    end
    if ($urandom_range(0, 99) < 25) run_level = !run_level;
    d[0] = run_level;
    d[1] = ($urandom_range(0, 99) < 4);
    d[2] = ($urandom_range(0, 99) < 60);
    for (int i = 0; i < NCH_IO; i++) begin
      // largest code that stays at or under the limit
      safe = ((32'(ctl.limit[i]) + 1) * 16384 - 1) / sense_gain(i);
      if (safe > 4095) safe = 4095;
      pick = $urandom_range(0, 199);
      if (pick < 2)      code = $urandom_range(0, 4095);
      else if (pick < 4) code = (safe == 4095) ? safe : safe + 1;
      else if (pick < 7) code = safe;
      else               code = $urandom_range(0, safe);
      d[KEY_BITS + SAMPLE_W*i +: SAMPLE_W] = SAMPLE_W'(code);
    end
    return d;
  endfunction

  initial begin
    logic [LIMIT_W-1:0] lim [NCH_IO];
    logic [TIME_W-1:0]  dur;
    int unsigned        phases;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    hold_off_req  = 0;
    run_level     = 0;
    src_idle_pct  = 27;
    snk_idle_pct  = 66;
    phases        = 7;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every mode and every transition but the timer expiry
    put(0, 0, 0, '{0, 0, 0, 0, 0});
    put(1, 1, 0, '{0, 0, 0, 0, 0});          // stop held blocks the start, alarm
    put(1, 0, 0, '{0, 0, 0, 0, 0});          // level without an edge
    put(0, 0, 1, '{0, 0, 0, 0, 0});
    put(1, 0, 0, '{0, 0, 0, 0, 0});          // start
    put(0, 0, 1, '{1000, 1000, 1000, 1000, 1000});
    put(1, 0, 0, '{0, 0, 0, 0, 0});          // run key ends the run
    put(0, 1, 1, '{4095, 4095, 4095, 4095, 4095});
    put(1, 0, 0, '{0, 0, 0, 0, 0});          // back to wait, double beep
    put(0, 0, 0, '{0, 0, 0, 0, 0});
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    put(0, 0, 0, '{4095, 4095, 4095, 4095, 4095});
    put(0, 1, 0, '{4095, 4095, 4095, 4095, 4095});
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    put(0, 0, 0, '{0, 0, 0, 0, 0});
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    put(0, 1, 0, '{0, 0, 4095, 0, 0});       // trip and stop together: stop wins
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    wait_idle();

    lim = '{'0, '0, '0, '0, '0};
    program_regs(16'd0, lim);
    put(0, 0, 0, '{0, 0, 0, 0, 0});
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    put(0, 0, 1, '{0, 0, 0, 0, 0});          // tick with countdown at zero
    put(1, 0, 0, '{0, 1, 0, 0, 0});
    put(0, 0, 0, '{0, 1, 0, 0, 0});          // expiry then trip, trip wins
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    wait_idle();

    foreach (lim[i]) lim[i] = LIMIT_W'(8191);
    program_regs(16'hFFFF, lim);
    put(0, 0, 0, '{0, 0, 0, 0, 0});
    put(1, 0, 0, '{0, 0, 0, 0, 0});
    put(0, 0, 1, '{4095, 4095, 4095, 4095, 4095});
    put(0, 1, 0, '{0, 0, 0, 0, 0});
    wait_idle();

    for (int p = 0; p < phases; p++) begin
      if (p < 3) begin
        src_idle_pct = 27;
        snk_idle_pct = 66;
      end else if (p < 5) begin
        src_idle_pct = 66;
        snk_idle_pct = 27;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (p)
        0: begin
          dur = 16'hFFFF;
          foreach (lim[i]) lim[i] = LIMIT_W'(8191);
        end
        1: begin
          dur = '0;
          foreach (lim[i]) lim[i] = '0;
        end
        2: begin
          dur = TIME_W'($urandom_range(1, 12));
          foreach (lim[i]) lim[i] = LIMIT_W'($urandom_range(0, 8191));
        end
        default: begin
          dur = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom_range(0, 65535))
                                             : TIME_W'($urandom_range(0, 20));
          foreach (lim[i]) lim[i] = LIMIT_W'($urandom_range(2000, 6000));
        end
      endcase
      wait_idle();
      program_regs(dur, lim);
      for (int b = 0; b < 200; b++) begin
        if (b == 60) hold_off_req = 1;
        if (p == 3 && b == 120) wait_idle();
        send_beat(make_random_beat());
      end
    end
    wait_idle();

    $display("%0d input beats, %0d result beats checked over %0d register settings",
             ctl.accepted, ctl.checked, phases + 3);
    $display("runs started %0d, timer expiries %0d, overcurrent trips %0d, stop key %0d",
             ctl.starts, ctl.expiries, ctl.trips, ctl.stops);
    if (ctl.errors == 0 && ctl.due_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
